>>> hw/rtl/vau_pkg.sv
// package for the three-component vector arithmetic unit
// holds word widths, action codes, payload structs, pipeline records and saturation helpers
// no dependencies
package vau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  // signed operand width, wide enough for a difference of two words
  localparam int MAG_BITS  = WORD_BITS + 1;
  localparam int PROD_BITS = 2 * MAG_BITS;
  localparam int ACC_BITS  = PROD_BITS + 2;
  // square root result width and numerator width of the divider
  localparam int ROOT_BITS = WORD_BITS + 1;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int SAT_BITS  = ACC_BITS + NUM_BITS;

  typedef enum logic [3:0] {
    ACT_ADD       = 4'd0,
    ACT_SUB       = 4'd1,
    ACT_DOT       = 4'd2,
    ACT_CROSS     = 4'd3,
    ACT_SCALE     = 4'd4,
    ACT_DIVIDE    = 4'd5,
    ACT_NORMALIZE = 4'd6,
    ACT_MAGNITUDE = 4'd7,
    ACT_DISTANCE  = 4'd8,
    ACT_SQDIST    = 4'd9,
    ACT_NEGATE    = 4'd10,
    ACT_EQUAL     = 4'd11
  } action_e;

  typedef struct packed {
    action_e                      action;
    logic signed [WORD_BITS-1:0]  a_x;
    logic signed [WORD_BITS-1:0]  a_y;
    logic signed [WORD_BITS-1:0]  a_z;
    logic signed [WORD_BITS-1:0]  b_x;
    logic signed [WORD_BITS-1:0]  b_y;
    logic signed [WORD_BITS-1:0]  b_z;
    logic signed [WORD_BITS-1:0]  scalar;
  } vau_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0]  res_x;
    logic signed [WORD_BITS-1:0]  res_y;
    logic signed [WORD_BITS-1:0]  res_z;
    logic signed [WORD_BITS-1:0]  res_scalar;
    logic                         div_zero;
    logic                         is_equal;
  } vau_out_t;

  // per-transaction data that rides along the whole pipeline
  typedef struct packed {
    action_e                      action;
    vau_out_t                     res;
    logic [2:0]                   a_neg;
    logic [2:0][WORD_BITS-1:0]    a_mag;
    logic                         dv_neg;
    logic [MAG_BITS-1:0]          dsor;
  } side_t;

  typedef struct packed {
    side_t                        side;
    logic [2*ROOT_BITS-1:0]       rad;
    logic [ROOT_BITS:0]           rem;
    logic [ROOT_BITS-1:0]         root;
  } sq_t;

  typedef struct packed {
    side_t                        side;
    logic [2:0][NUM_BITS-1:0]     num;
    logic [2:0][MAG_BITS-1:0]     rem;
    logic [2:0][NUM_BITS-1:0]     quo;
  } dv_t;

  // sign and magnitude to a saturated word
  function automatic logic [WORD_BITS-1:0] sat_word(input logic neg,
                                                   input logic [SAT_BITS-1:0] mag);
    logic [WORD_BITS-1:0] lim;
    logic                 over;
    lim  = {1'b1, {(WORD_BITS-1){1'b0}}};
    over = (mag >= SAT_BITS'(lim));
    if (neg) begin
      return over ? lim : ((~mag[WORD_BITS-1:0]) + WORD_BITS'(1));
    end
    return over ? ~lim : mag[WORD_BITS-1:0];
  endfunction

  // saturate a signed operand-width value
  function automatic logic [WORD_BITS-1:0] sat_mw(input logic signed [MAG_BITS-1:0] v);
    logic                neg;
    logic [MAG_BITS-1:0] mag;
    neg = v[MAG_BITS-1];
    mag = neg ? MAG_BITS'(-v) : MAG_BITS'(v);
    return sat_word(neg, SAT_BITS'(mag));
  endfunction

  // drop fraction bits toward zero, then saturate
  function automatic logic [WORD_BITS-1:0] fix_sat(input logic signed [ACC_BITS-1:0] v);
    logic                neg;
    logic [ACC_BITS-1:0] mag;
    neg = v[ACC_BITS-1];
    mag = neg ? ACC_BITS'(-v) : ACC_BITS'(v);
    return sat_word(neg, SAT_BITS'(mag >> FRAC_BITS));
  endfunction

endpackage

>>> hw/rtl/vector3_arithmetic_unit.sv
// Operands and results are Q16.16; each transaction runs through every stage from start to done_o.
// Throughput: one transaction per cycle; busy stays low, every stage is pipelined
// (one root bit per square-root stage, one quotient bit per divider stage).
// The result is on res_o for exactly one cycle while done_o is high.
// Reset clears all valid bits; data registers are not reset.
// Depends on vau_pkg.
module vector3_arithmetic_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  vau_pkg::vau_in_t in_i,
  output logic             done_o,
  output vau_pkg::vau_out_t res_o
);
  import vau_pkg::*;

  localparam int W = WORD_BITS;

  assign busy = 1'b0;

  // stage 1: input register
  logic    v1_q;
  vau_in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start & ~busy) begin
      in_q <= in_i;
    end
  end

  // stage 2: differences, simple results and multiplier operands
  logic signed [MAG_BITS-1:0] av [3];
  logic signed [MAG_BITS-1:0] bv [3];
  logic signed [MAG_BITS-1:0] dv [3];
  logic signed [MAG_BITS-1:0] nav [3];
  logic signed [MAG_BITS-1:0] sv;
  logic signed [MAG_BITS-1:0] nsv;
  logic signed [MAG_BITS-1:0] opa_d [6];
  logic signed [MAG_BITS-1:0] opb_d [6];
  logic signed [MAG_BITS-1:0] opa_q [6];
  logic signed [MAG_BITS-1:0] opb_q [6];
  side_t                      side2_d, side2_q;
  logic                       v2_q;

  always_comb begin
    av[0] = {in_q.a_x[W-1], in_q.a_x};
    av[1] = {in_q.a_y[W-1], in_q.a_y};
    av[2] = {in_q.a_z[W-1], in_q.a_z};
    bv[0] = {in_q.b_x[W-1], in_q.b_x};
    bv[1] = {in_q.b_y[W-1], in_q.b_y};
    bv[2] = {in_q.b_z[W-1], in_q.b_z};
    sv    = {in_q.scalar[W-1], in_q.scalar};
    nsv   = -sv;
    for (int i = 0; i < 3; i++) begin
      dv[i]  = av[i] - bv[i];
      nav[i] = -av[i];
    end
    for (int i = 0; i < 6; i++) begin
      opa_d[i] = '0;
      opb_d[i] = '0;
    end

    side2_d        = '0;
    side2_d.action = in_q.action;
    for (int i = 0; i < 3; i++) begin
      side2_d.a_neg[i] = av[i][MAG_BITS-1];
      side2_d.a_mag[i] = av[i][MAG_BITS-1] ? nav[i][W-1:0] : av[i][W-1:0];
    end
    side2_d.dv_neg = sv[MAG_BITS-1];
    side2_d.dsor   = sv[MAG_BITS-1] ? nsv : sv;

    case (in_q.action)
      ACT_ADD: begin
        side2_d.res.res_x = sat_mw(av[0] + bv[0]);
        side2_d.res.res_y = sat_mw(av[1] + bv[1]);
        side2_d.res.res_z = sat_mw(av[2] + bv[2]);
      end
      ACT_SUB: begin
        side2_d.res.res_x = sat_mw(dv[0]);
        side2_d.res.res_y = sat_mw(dv[1]);
        side2_d.res.res_z = sat_mw(dv[2]);
      end
      ACT_NEGATE: begin
        side2_d.res.res_x = sat_mw(nav[0]);
        side2_d.res.res_y = sat_mw(nav[1]);
        side2_d.res.res_z = sat_mw(nav[2]);
      end
      ACT_EQUAL: begin
        side2_d.res.is_equal = (dv[0] == '0) && (dv[1] == '0) && (dv[2] == '0);
      end
      ACT_DIVIDE: begin
        side2_d.res.div_zero = (sv == '0);
      end
      ACT_DOT: begin
        for (int i = 0; i < 3; i++) begin
          opa_d[i] = av[i];
          opb_d[i] = bv[i];
        end
      end
      ACT_CROSS: begin
        opa_d[0] = av[1]; opb_d[0] = bv[2];
        opa_d[1] = av[2]; opb_d[1] = bv[1];
        opa_d[2] = av[2]; opb_d[2] = bv[0];
        opa_d[3] = av[0]; opb_d[3] = bv[2];
        opa_d[4] = av[0]; opb_d[4] = bv[1];
        opa_d[5] = av[1]; opb_d[5] = bv[0];
      end
      ACT_SCALE: begin
        opa_d[0] = av[0]; opb_d[0] = sv;
        opa_d[2] = av[1]; opb_d[2] = sv;
        opa_d[4] = av[2]; opb_d[4] = sv;
      end
      ACT_DISTANCE, ACT_SQDIST: begin
        for (int i = 0; i < 3; i++) begin
          opa_d[i] = dv[i];
          opb_d[i] = dv[i];
        end
      end
      ACT_NORMALIZE, ACT_MAGNITUDE: begin
        for (int i = 0; i < 3; i++) begin
          opa_d[i] = av[i];
          opb_d[i] = av[i];
        end
      end
      default: begin
      end
    endcase
  end

  // stage 3: products
  logic signed [PROD_BITS-1:0] prod_q [6];
  side_t                       side3_q;
  logic                        v3_q;

  // stage 4: sums
  logic signed [ACC_BITS-1:0] acc_q [4];
  side_t                      side4_q;
  logic                       v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
    side3_q <= side2_q;
    side4_q <= side3_q;
    for (int i = 0; i < 6; i++) begin
      opa_q[i]  <= opa_d[i];
      opb_q[i]  <= opb_d[i];
      prod_q[i] <= opa_q[i] * opb_q[i];
    end
    acc_q[0] <= ACC_BITS'(prod_q[0]) + ACC_BITS'(prod_q[1]) + ACC_BITS'(prod_q[2]);
    acc_q[1] <= ACC_BITS'(prod_q[0]) - ACC_BITS'(prod_q[1]);
    acc_q[2] <= ACC_BITS'(prod_q[2]) - ACC_BITS'(prod_q[3]);
    acc_q[3] <= ACC_BITS'(prod_q[4]) - ACC_BITS'(prod_q[5]);
  end

  // stage 5: fraction drop and saturation, square root setup
  sq_t  sq_d;
  sq_t  sq_q [ROOT_BITS+1];
  logic [ROOT_BITS:0] sqv_q;

  always_comb begin
    sq_d      = '0;
    sq_d.side = side4_q;
    sq_d.rad  = acc_q[0][2*ROOT_BITS-1:0];
    case (side4_q.action)
      ACT_DOT, ACT_SQDIST: begin
        sq_d.side.res.res_scalar = fix_sat(acc_q[0]);
      end
      ACT_CROSS, ACT_SCALE: begin
        sq_d.side.res.res_x = fix_sat(acc_q[1]);
        sq_d.side.res.res_y = fix_sat(acc_q[2]);
        sq_d.side.res.res_z = fix_sat(acc_q[3]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sqv_q[0] <= 1'b0;
    end else begin
      sqv_q[0] <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q[0] <= sq_d;
  end

  // square root, one root bit per stage
  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
    sq_t                nxt;
    logic [ROOT_BITS+2:0] sh;
    logic [ROOT_BITS+2:0] trial;
    logic [ROOT_BITS+2:0] diff;
    logic                 ge;

    always_comb begin
      sh       = {sq_q[k].rem, sq_q[k].rad[2*ROOT_BITS-1 -: 2]};
      trial    = {1'b0, sq_q[k].root, 2'b01};
      diff     = sh - trial;
      ge       = (sh >= trial);
      nxt      = sq_q[k];
      nxt.rad  = {sq_q[k].rad[2*ROOT_BITS-3:0], 2'b00};
      nxt.rem  = ge ? diff[ROOT_BITS:0] : sh[ROOT_BITS:0];
      nxt.root = {sq_q[k].root[ROOT_BITS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sqv_q[k+1] <= 1'b0;
      end else begin
        sqv_q[k+1] <= sqv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq_q[k+1] <= nxt;
    end
  end

  // root select and divider setup
  dv_t  dv_d;
  dv_t  dv_q [NUM_BITS+1];
  logic [NUM_BITS:0] dvv_q;

  always_comb begin
    dv_d      = '0;
    dv_d.side = sq_q[ROOT_BITS].side;
    for (int i = 0; i < 3; i++) begin
      dv_d.num[i] = {dv_d.side.a_mag[i], {FRAC_BITS{1'b0}}};
    end
    case (dv_d.side.action)
      ACT_MAGNITUDE, ACT_DISTANCE: begin
        dv_d.side.res.res_scalar = sat_word(1'b0, SAT_BITS'(sq_q[ROOT_BITS].root));
      end
      ACT_NORMALIZE: begin
        dv_d.side.dsor   = MAG_BITS'(sq_q[ROOT_BITS].root);
        dv_d.side.dv_neg = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvv_q[0] <= 1'b0;
    end else begin
      dvv_q[0] <= sqv_q[ROOT_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= dv_d;
  end

  // restoring divider, one quotient bit per stage on three lanes
  for (genvar k = 0; k < NUM_BITS; k++) begin : g_div
    dv_t                nxt;
    logic [MAG_BITS:0]  sh   [3];
    logic [MAG_BITS:0]  diff [3];
    logic [2:0]         ge;

    always_comb begin
      nxt = dv_q[k];
      for (int i = 0; i < 3; i++) begin
        sh[i]      = {dv_q[k].rem[i], dv_q[k].num[i][NUM_BITS-1]};
        diff[i]    = sh[i] - {1'b0, dv_q[k].side.dsor};
        ge[i]      = (sh[i] >= {1'b0, dv_q[k].side.dsor});
        nxt.rem[i] = ge[i] ? diff[i][MAG_BITS-1:0] : sh[i][MAG_BITS-1:0];
        nxt.num[i] = {dv_q[k].num[i][NUM_BITS-2:0], 1'b0};
        nxt.quo[i] = {dv_q[k].quo[i][NUM_BITS-2:0], ge[i]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dvv_q[k+1] <= 1'b0;
      end else begin
        dvv_q[k+1] <= dvv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      dv_q[k+1] <= nxt;
    end
  end

  // quotient sign and saturation, output register
  vau_out_t res_d, res_q;
  logic     done_q;
  side_t    sd;
  logic     qvalid;

  always_comb begin
    sd     = dv_q[NUM_BITS].side;
    res_d  = sd.res;
    qvalid = 1'b0;
    case (sd.action)
      ACT_DIVIDE:    qvalid = ~sd.res.div_zero;
      ACT_NORMALIZE: qvalid = (sd.dsor != '0);
      default:       qvalid = 1'b0;
    endcase
    if (qvalid) begin
      res_d.res_x = sat_word(sd.a_neg[0] ^ sd.dv_neg, SAT_BITS'(dv_q[NUM_BITS].quo[0]));
      res_d.res_y = sat_word(sd.a_neg[1] ^ sd.dv_neg, SAT_BITS'(dv_q[NUM_BITS].quo[1]));
      res_d.res_z = sat_word(sd.a_neg[2] ^ sd.dv_neg, SAT_BITS'(dv_q[NUM_BITS].quo[2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dvv_q[NUM_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> test/tb_vector3_arithmetic_unit.sv
// self-checking testbench for vector3_arithmetic_unit: directed table then random transactions,
// results checked field by field against typed expectations or an in-bench predictor with wide exact arithmetic
// depends on vau_pkg and the vector3_arithmetic_unit rtl
module tb_vector3_arithmetic_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import vau_pkg::*;

  typedef logic signed [129:0] big_t;

  localparam big_t WMAX = big_t'(64'sd2147483647);
  localparam big_t WMIN = -big_t'(64'sd2147483648);
  localparam int   LATENCY = 2 * WORD_BITS + FRAC_BITS + 8;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   NUM_RANDOM = 600;

  typedef struct {
    vau_in_t  stim;
    logic     typed;
    vau_out_t want;
  } row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  vau_in_t  in_i = '0;
  logic     done_o;
  vau_out_t res_o;

  vau_out_t pending_q[$];
  row_t     dir_rows[$];
  int       errors = 0;
  int       cycles = 0;
  logic     use_typed = 1'b0;
  vau_out_t typed_want;

  vector3_arithmetic_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always #5 clk_i = ~clk_i;

  // clamp an exact value to the signed word range
  function automatic logic [WORD_BITS-1:0] clamp_word(big_t v);
    if (v > WMAX) return WMAX[WORD_BITS-1:0];
    if (v < WMIN) return WMIN[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

  // product sum in q32.32 back to q16.16, truncated toward zero
  function automatic logic [WORD_BITS-1:0] drop_frac(big_t v);
    return clamp_word(v / big_t'(65536));
  endfunction

  function automatic big_t int_sqrt(big_t s);
    big_t r;
    big_t t;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (big_t'(1) <<< b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // expected result of one transaction
  function automatic vau_out_t vector_result(vau_in_t t);
    vau_out_t o;
    big_t     a[3];
    big_t     b[3];
    big_t     d[3];
    big_t     s;
    big_t     acc;
    big_t     mag;
    o = '0;
    a[0] = big_t'(t.a_x); a[1] = big_t'(t.a_y); a[2] = big_t'(t.a_z);
    b[0] = big_t'(t.b_x); b[1] = big_t'(t.b_y); b[2] = big_t'(t.b_z);
    s = big_t'(t.scalar);
    for (int i = 0; i < 3; i++) d[i] = a[i] - b[i];
    case (t.action)
      ACT_ADD: begin
        o.res_x = clamp_word(a[0] + b[0]);
        o.res_y = clamp_word(a[1] + b[1]);
        o.res_z = clamp_word(a[2] + b[2]);
      end
      ACT_SUB: begin
        o.res_x = clamp_word(d[0]); o.res_y = clamp_word(d[1]); o.res_z = clamp_word(d[2]);
      end
      ACT_DOT: o.res_scalar = drop_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
      ACT_CROSS: begin
        o.res_x = drop_frac(a[1] * b[2] - a[2] * b[1]);
        o.res_y = drop_frac(a[2] * b[0] - a[0] * b[2]);
        o.res_z = drop_frac(a[0] * b[1] - a[1] * b[0]);
      end
      ACT_SCALE: begin
        o.res_x = drop_frac(a[0] * s); o.res_y = drop_frac(a[1] * s);
        o.res_z = drop_frac(a[2] * s);
      end
      ACT_DIVIDE: begin
        if (s == 0) o.div_zero = 1'b1;
        else begin
          o.res_x = clamp_word((a[0] <<< FRAC_BITS) / s);
          o.res_y = clamp_word((a[1] <<< FRAC_BITS) / s);
          o.res_z = clamp_word((a[2] <<< FRAC_BITS) / s);
        end
      end
      ACT_NORMALIZE: begin
        mag = int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (mag != 0) begin
          o.res_x = clamp_word((a[0] <<< FRAC_BITS) / mag);
          o.res_y = clamp_word((a[1] <<< FRAC_BITS) / mag);
          o.res_z = clamp_word((a[2] <<< FRAC_BITS) / mag);
        end
      end
      ACT_MAGNITUDE: o.res_scalar = clamp_word(int_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]));
      ACT_DISTANCE: o.res_scalar = clamp_word(int_sqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]));
      ACT_SQDIST: begin
        acc = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        o.res_scalar = drop_frac(acc);
      end
      ACT_NEGATE: begin
        o.res_x = clamp_word(-a[0]); o.res_y = clamp_word(-a[1]); o.res_z = clamp_word(-a[2]);
      end
      ACT_EQUAL: o.is_equal = (d[0] == 0) && (d[1] == 0) && (d[2] == 0);
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [WORD_BITS-1:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return WORD_BITS'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
      4, 5, 6: return $urandom;
      7: return WMAX[WORD_BITS-1:0];
      8: return WMIN[WORD_BITS-1:0];
      default: return WORD_BITS'($signed($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  function automatic vau_in_t rand_item();
    vau_in_t t;
    t.action = ($urandom_range(0, 19) == 0) ? action_e'($urandom_range(12, 15))
                                            : action_e'($urandom_range(0, 11));
    t.a_x = rand_word(); t.a_y = rand_word(); t.a_z = rand_word();
    t.b_x = rand_word(); t.b_y = rand_word(); t.b_z = rand_word();
    t.scalar = ($urandom_range(0, 7) == 0) ? '0 : rand_word();
    // equality hits and near misses
    if (t.action == ACT_EQUAL && $urandom_range(0, 2) != 0) begin
      t.b_x = t.a_x; t.b_y = t.a_y; t.b_z = t.a_z;
      if ($urandom_range(0, 2) == 0) t.b_z[$urandom_range(0, WORD_BITS - 1)] ^= 1'b1;
    end
    return t;
  endfunction

  function automatic vau_in_t mk(action_e op, logic [WORD_BITS-1:0] ax, logic [WORD_BITS-1:0] ay,
                                 logic [WORD_BITS-1:0] az, logic [WORD_BITS-1:0] bx,
                                 logic [WORD_BITS-1:0] by, logic [WORD_BITS-1:0] bz,
                                 logic [WORD_BITS-1:0] sc);
    vau_in_t t;
    t.action = op; t.a_x = ax; t.a_y = ay; t.a_z = az;
    t.b_x = bx; t.b_y = by; t.b_z = bz; t.scalar = sc;
    return t;
  endfunction

  function automatic vau_out_t mk_res(logic [WORD_BITS-1:0] x, logic [WORD_BITS-1:0] y,
                                      logic [WORD_BITS-1:0] z, logic [WORD_BITS-1:0] sc,
                                      logic dz, logic eq);
    vau_out_t o;
    o.res_x = x; o.res_y = y; o.res_z = z; o.res_scalar = sc;
    o.div_zero = dz; o.is_equal = eq;
    return o;
  endfunction

  // directed table: typed expectation where obvious, predictor otherwise
  task automatic add_row(vau_in_t t, logic typed, vau_out_t want);
    row_t r;
    r.stim = t; r.typed = typed; r.want = want;
    dir_rows.push_back(r);
  endtask

  task automatic build_table();
    logic [WORD_BITS-1:0] mx;
    logic [WORD_BITS-1:0] mn;
    logic [WORD_BITS-1:0] one;
    mx = WMAX[WORD_BITS-1:0]; mn = WMIN[WORD_BITS-1:0]; one = 32'h0001_0000;
    add_row(mk(ACT_ADD, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0);
    add_row(mk(ACT_ADD, mx, mn, mx, mx, mn, 0, 0), 1'b1, mk_res(mx, mn, mx, 0, 0, 0));
    add_row(mk(ACT_SUB, mn, mx, 0, mx, mn, 0, 0), 1'b1, mk_res(mn, mx, 0, 0, 0, 0));
    add_row(mk(ACT_DOT, mx, mx, mx, mx, mx, mx, 0), 1'b1, mk_res(0, 0, 0, mx, 0, 0));
    add_row(mk(ACT_DOT, mn, mn, mn, mx, mx, mx, 0), 1'b1, mk_res(0, 0, 0, mn, 0, 0));
    add_row(mk(ACT_CROSS, one, 0, 0, 0, one, 0, 0), 1'b1, mk_res(0, 0, one, 0, 0, 0));
    add_row(mk(ACT_CROSS, mx, mn, mx, mn, mx, mn, 0), 1'b0, '0);
    add_row(mk(ACT_SCALE, mx, mn, one, 0, 0, 0, mx), 1'b1, mk_res(mx, mn, mx, 0, 0, 0));
    add_row(mk(ACT_SCALE, -32'sd1, 1, 3, 0, 0, 0, 32'h0000_8000), 1'b1,
            mk_res(0, 0, 1, 0, 0, 0));
    add_row(mk(ACT_DIVIDE, mx, mn, one, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 0, 1, 0));
    add_row(mk(ACT_DIVIDE, mx, mn, one, 0, 0, 0, 1), 1'b1, mk_res(mx, mn, mx, 0, 0, 0));
    add_row(mk(ACT_DIVIDE, mn, mx, 7, 0, 0, 0, mn), 1'b0, '0);
    add_row(mk(ACT_NORMALIZE, 0, 0, 0, mx, mx, mx, mx), 1'b1, '0);
    add_row(mk(ACT_NORMALIZE, one, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(one, 0, 0, 0, 0, 0));
    add_row(mk(ACT_NORMALIZE, mn, mx, 1, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(ACT_MAGNITUDE, mn, mn, mn, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, mx, 0, 0));
    add_row(mk(ACT_MAGNITUDE, 3, 4, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 5, 0, 0));
    add_row(mk(ACT_DISTANCE, mx, mx, mx, mn, mn, mn, 0), 1'b1, mk_res(0, 0, 0, mx, 0, 0));
    add_row(mk(ACT_SQDIST, mx, 0, 0, mn, 0, 0, 0), 1'b1, mk_res(0, 0, 0, mx, 0, 0));
    add_row(mk(ACT_SQDIST, one, 0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, one, 0, 0));
    add_row(mk(ACT_NEGATE, mn, mx, 0, 0, 0, 0, 0), 1'b1, mk_res(mx, mn + 1, 0, 0, 0, 0));
    add_row(mk(ACT_EQUAL, mn, mx, 5, mn, mx, 5, 0), 1'b1, mk_res(0, 0, 0, 0, 0, 1));
    add_row(mk(ACT_EQUAL, mn, mx, 5, mn, mx, 4, 0), 1'b1, '0);
    add_row(mk(action_e'(4'd12), mx, mx, mx, mx, mx, mx, mx), 1'b1, '0);
    add_row(mk(action_e'(4'd15), mn, mn, mn, mn, mn, mn, mn), 1'b1, '0);
  endtask

  // record the expectation of each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      if (use_typed) pending_q.push_back(typed_want);
      else pending_q.push_back(vector_result(in_i));
    end
  end

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    vau_out_t w;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        w = pending_q.pop_front();
        if (res_o.res_x !== w.res_x) begin
          $error("res_x expected %h actual %h", w.res_x, res_o.res_x); errors++;
        end
        if (res_o.res_y !== w.res_y) begin
          $error("res_y expected %h actual %h", w.res_y, res_o.res_y); errors++;
        end
        if (res_o.res_z !== w.res_z) begin
          $error("res_z expected %h actual %h", w.res_z, res_o.res_z); errors++;
        end
        if (res_o.res_scalar !== w.res_scalar) begin
          $error("res_scalar expected %h actual %h", w.res_scalar, res_o.res_scalar); errors++;
        end
        if (res_o.div_zero !== w.div_zero) begin
          $error("div_zero expected %b actual %b", w.div_zero, res_o.div_zero); errors++;
        end
        if (res_o.is_equal !== w.is_equal) begin
          $error("is_equal expected %b actual %b", w.is_equal, res_o.is_equal); errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // present one transaction, sometimes with a random gap before it outside the quiet stretch
  task automatic send(vau_in_t t, logic typed, vau_out_t want, logic quiet);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start <= 1'b1;
    in_i <= t;
    use_typed <= typed;
    typed_want <= want;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    build_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) send(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    for (int n = 0; n < NUM_RANDOM; n++) begin
      // drain the pipeline once with the sender held off
      if (n == 300) begin
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk_i);
      end
      send(rand_item(), 1'b0, '0, n >= 150 && n < 280);
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
